// ===== hdl/pvpr_pkg.sv =====
// pvpr_pkg: shared constants, codes and helpers for the paired valve pwm ramp unit
// no dependencies; imported by paired_valve_pwm_ramp_unit
`default_nettype none

package pvpr_pkg;

    // channel layout
    localparam int NUM_VALVES  = 6;
    localparam int VALVE_W     = 3;
    localparam int LAST_VALVE  = 5;
    localparam int PAIR_OFFSET = 3;

    // percent and duty
    localparam int PCT_W    = 7;
    localparam int PCT_FULL = 100;
    localparam int DUTY_W   = 8;
    localparam int DUTY_MAX = 255;

    // division by 100 as a reciprocal multiply, exact for products below 2^15
    localparam int RECIP_100   = 5243;
    localparam int RECIP_SHIFT = 19;
    localparam int MUL_A_W     = 15;
    localparam int MUL_B_W     = 13;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

    // command and result fields
    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 2;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_SCALE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_FIRST   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_LAST    = CFG_IDX_W'(NUM_VALVES);
    localparam logic [CFG_DATA_W-1:0] DRIVE_SCALE_RST = CFG_DATA_W'(60);

    // command codes
    typedef enum logic [FUNC_W-1:0] {
        FN_TICK       = 3'd0,
        FN_SET_GOAL   = 3'd1,
        FN_SET_SCALED = 3'd2,
        FN_DIRECT     = 3'd3,
        FN_ALL_OFF    = 3'd4
    } t_func;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_VALVE = 2'd2
    } t_status;

    // opposing valve of a pair
    function automatic logic [VALVE_W-1:0] pair_of(input logic [VALVE_W-1:0] v);
        return (v >= VALVE_W'(PAIR_OFFSET)) ? v - VALVE_W'(PAIR_OFFSET)
                                            : v + VALVE_W'(PAIR_OFFSET);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/paired_valve_pwm_ramp_unit.sv =====
// paired_valve_pwm_ramp_unit: six valve pwm channels in opposing pairs with 1% ramping
// depends on pvpr_pkg (constants, command and status codes, pair helper)
//
// Usage: commands enter on the input channel (i_valid / o_stall) as func, valve,
// value and the two deadman flags. Each command yields exactly one result item on
// the output channel (o_valid / i_stall): the six pin duties and a status code.
// One command is in flight at a time; o_stall stays high from acceptance until the
// result item has been taken. All arithmetic goes through one shared multiplier
// (15 x 13 bits) under a small sequencer; division by 100 is a second pass through
// it with a reciprocal. Paths from acceptance to result valid:
//   rejected command (other than a scaled goal over range), all off, unused code: straight to result
//   scaled goal whose lifted goal is over range: the scaled-goal steps, then the result
//   direct set: duty multiply, divide and write for that valve
//   tick: each channel in index order; a channel that moves takes duty multiply, divide and write
//   set goal: same as tick; scaled goal: the scaled-goal steps, then as set goal
// The result stays valid and unchanged while i_stall is high; the next command is
// accepted in the cycle after the result is taken. Configuration writes are taken
// in any cycle and should only be issued while the block is idle. Synchronous
// reset clears all goals, percents and duties, sets drive scale to 60 and the
// low-movement offsets to 0.
`default_nettype none

module paired_valve_pwm_ramp_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // command channel
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [pvpr_pkg::FUNC_W-1:0]       i_func,
    input  wire logic [pvpr_pkg::VALVE_W-1:0]      i_valve,
    input  wire logic [pvpr_pkg::PCT_W-1:0]        i_value,
    input  wire logic                              i_deadman_held,
    input  wire logic                              i_deadman_forced,
    // result channel
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic [pvpr_pkg::DUTY_W-1:0]            o_duty_0,
    output logic [pvpr_pkg::DUTY_W-1:0]            o_duty_1,
    output logic [pvpr_pkg::DUTY_W-1:0]            o_duty_2,
    output logic [pvpr_pkg::DUTY_W-1:0]            o_duty_3,
    output logic [pvpr_pkg::DUTY_W-1:0]            o_duty_4,
    output logic [pvpr_pkg::DUTY_W-1:0]            o_duty_5,
    output logic [pvpr_pkg::STATUS_W-1:0]          o_status,
    // configuration write port
    input  wire logic                              i_cfg_we,
    input  wire logic [pvpr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [pvpr_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import pvpr_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_SC_MUL   = 11'b000_0000_0010,
        S_SC_DIV   = 11'b000_0000_0100,
        S_SC_OFS   = 11'b000_0000_1000,
        S_SC_DIV2  = 11'b000_0001_0000,
        S_SC_GOAL  = 11'b000_0010_0000,
        S_SCAN     = 11'b000_0100_0000,
        S_DUTY_MUL = 11'b000_1000_0000,
        S_DUTY_DIV = 11'b001_0000_0000,
        S_WRITE    = 11'b010_0000_0000,
        S_DONE     = 11'b100_0000_0000
    } t_state;

    t_state                  r_state;
    t_status                 r_status;

    // configuration registers
    logic [CFG_DATA_W-1:0]   r_scale;
    logic [PCT_W-1:0]        r_low [NUM_VALVES];

    // channel state
    logic [PCT_W-1:0]        r_goal [NUM_VALVES];
    logic [PCT_W-1:0]        r_cur  [NUM_VALVES];
    logic [DUTY_W-1:0]       r_pin  [NUM_VALVES];

    // command payload and working registers
    logic [VALVE_W-1:0]      r_valve;
    logic [PCT_W-1:0]        r_value;
    logic                    r_dm_pass;
    logic                    r_in_tick;
    logic [VALVE_W-1:0]      r_idx;
    logic [PCT_W-1:0]        r_pct;
    logic [PROD_W-1:0]       r_acc;

    // shared multiplier
    logic [MUL_A_W-1:0]      mul_a;
    logic [MUL_B_W-1:0]      mul_b;
    logic [PROD_W-1:0]       n_acc;

    logic [QUOT_W-1:0]       w_quot;
    logic [DUTY_W-1:0]       w_duty;
    logic [PCT_W-1:0]        w_low;
    logic                    w_low_over;
    logic [PCT_W-1:0]        w_low_span;
    logic [QUOT_W-1:0]       w_goal_sc;
    logic [PCT_W-1:0]        w_goal;
    logic [PCT_W-1:0]        w_cur;
    logic [VALVE_W-1:0]      w_other;

    // quotient of the last reciprocal pass, duty clamp
    assign w_quot = r_acc[PROD_W-1 -: QUOT_W];
    assign w_duty = (w_quot > QUOT_W'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX) : w_quot[DUTY_W-1:0];

    // low-movement offset terms for the scaled goal
    assign w_low      = r_low[r_valve];
    assign w_low_over = (w_low > PCT_W'(PCT_FULL));
    assign w_low_span = w_low_over ? (w_low - PCT_W'(PCT_FULL)) : (PCT_W'(PCT_FULL) - w_low);
    assign w_goal_sc  = w_low_over ? (QUOT_W'(w_low) - w_quot) : (w_quot + QUOT_W'(w_low));

    // channel under the sequencer
    assign w_goal  = r_goal[r_idx];
    assign w_cur   = r_cur[r_idx];
    assign w_other = pair_of(r_idx);

    // operand select for the shared multiplier
    always_comb begin
        case (r_state)
            S_SC_MUL: begin
                mul_a = MUL_A_W'(r_value);
                mul_b = MUL_B_W'(r_scale);
            end
            S_SC_OFS: begin
                mul_a = MUL_A_W'(w_quot);
                mul_b = MUL_B_W'(w_low_span);
            end
            S_DUTY_MUL: begin
                mul_a = MUL_A_W'(r_pct);
                mul_b = MUL_B_W'(DUTY_MAX);
            end
            default: begin
                mul_a = r_acc[MUL_A_W-1:0];
                mul_b = MUL_B_W'(RECIP_100);
            end
        endcase
        n_acc = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= DRIVE_SCALE_RST;
            for (int k = 0; k < NUM_VALVES; k++) begin
                r_low[VALVE_W'(k)] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_DRIVE_SCALE) begin
                r_scale <= i_cfg_data;
            end else if (i_cfg_idx >= CFG_LOW_FIRST && i_cfg_idx <= CFG_LOW_LAST) begin
                r_low[VALVE_W'(i_cfg_idx - CFG_LOW_FIRST)] <= PCT_W'(i_cfg_data);
            end
        end
    end

    // command payload capture
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_valve   <= i_valve;
            r_value   <= i_value;
            r_dm_pass <= i_deadman_held || !i_deadman_forced;
        end
        r_acc <= n_acc;
    end

    // sequencer and channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_status  <= ST_OK;
            r_idx     <= '0;
            r_pct     <= '0;
            r_in_tick <= 1'b0;
            for (int k = 0; k < NUM_VALVES; k++) begin
                r_goal[VALVE_W'(k)] <= '0;
                r_cur[VALVE_W'(k)]  <= '0;
                r_pin[VALVE_W'(k)]  <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_status  <= ST_OK;
                        r_idx     <= '0;
                        r_in_tick <= 1'b1;
                        case (i_func)
                            FN_TICK: begin
                                r_state <= S_SCAN;
                            end
                            FN_SET_GOAL: begin
                                if (i_value > PCT_W'(PCT_FULL)) begin
                                    r_status <= ST_RANGE;
                                    r_state  <= S_DONE;
                                end else if (i_valve > VALVE_W'(LAST_VALVE)) begin
                                    r_status <= ST_VALVE;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_goal[i_valve] <= i_value;
                                    r_state         <= S_SCAN;
                                end
                            end
                            FN_SET_SCALED: begin
                                if (i_valve > VALVE_W'(LAST_VALVE)) begin
                                    r_status <= ST_VALVE;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_state <= S_SC_MUL;
                                end
                            end
                            FN_DIRECT: begin
                                if (i_value > PCT_W'(PCT_FULL)) begin
                                    r_status <= ST_RANGE;
                                    r_state  <= S_DONE;
                                end else if (i_valve > VALVE_W'(LAST_VALVE)) begin
                                    r_status <= ST_VALVE;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_idx     <= i_valve;
                                    r_pct     <= i_value;
                                    r_in_tick <= 1'b0;
                                    r_state   <= S_DUTY_MUL;
                                end
                            end
                            FN_ALL_OFF: begin
                                // all off clears every channel's goal, percent and duty directly, without ramping
                                for (int k = 0; k < NUM_VALVES; k++) begin
                                    r_goal[VALVE_W'(k)] <= '0;
                                    r_cur[VALVE_W'(k)]  <= '0;
                                    r_pin[VALVE_W'(k)]  <= '0;
                                end
                                r_state <= S_DONE;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                // scaled goal: value*scale/100, then scaled by the span to 100 and offset by the low-movement point
                S_SC_MUL:  r_state <= S_SC_DIV;
                S_SC_DIV:  r_state <= S_SC_OFS;
                S_SC_OFS:  r_state <= S_SC_DIV2;
                S_SC_DIV2: r_state <= S_SC_GOAL;
                S_SC_GOAL: begin
                    if (w_goal_sc > QUOT_W'(PCT_FULL)) begin
                        r_status <= ST_RANGE;
                        r_state  <= S_DONE;
                    end else begin
                        r_goal[r_valve] <= w_goal_sc[PCT_W-1:0];
                        r_idx           <= '0;
                        r_state         <= S_SCAN;
                    end
                end
                // tick: step each channel 1% toward its goal, in index order
                S_SCAN: begin
                    if (w_goal != w_cur) begin
                        r_pct   <= (w_goal > w_cur) ? (w_cur + 1'b1) : (w_cur - 1'b1);
                        r_state <= S_DUTY_MUL;
                    end else if (r_idx == VALVE_W'(LAST_VALVE)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                // duty = pct*DUTY_MAX/100
                S_DUTY_MUL: r_state <= S_DUTY_DIV;
                S_DUTY_DIV: r_state <= S_WRITE;
                S_WRITE: begin
                    // opposing valve off, then this valve's pin if the duty is zero or the deadman allows
                    r_pin[w_other]  <= '0;
                    r_cur[w_other]  <= '0;
                    r_goal[w_other] <= '0;
                    if (w_duty == '0 || r_dm_pass) begin
                        r_pin[r_idx] <= w_duty;
                    end
                    r_cur[r_idx] <= r_pct;
                    if (r_in_tick && r_idx != VALVE_W'(LAST_VALVE)) begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_SCAN;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                // hold the result item until taken
                S_DONE: begin
                    if (!i_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // handshake and result payload
    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = (r_state == S_DONE);
    assign o_duty_0 = r_pin[0];
    assign o_duty_1 = r_pin[1];
    assign o_duty_2 = r_pin[2];
    assign o_duty_3 = r_pin[3];
    assign o_duty_4 = r_pin[4];
    assign o_duty_5 = r_pin[5];
    assign o_status = r_status;

endmodule

`default_nettype wire
